FILE: rtl/lgs_pkg.sv
package lgs_pkg;

    localparam int GRID_MAX = 64;
    localparam int CFG_W    = 7;
    localparam int COORD_W  = 6;

    localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 7'd64;
    localparam logic [CFG_W-1:0] MIN_ACTIVE      = 7'd3;

    // register index, taken from byte address bit 2
    localparam logic REG_GRID_SIZE = 1'b0;

    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_READ    = 2'd1;
    localparam logic [1:0] KIND_ADVANCE = 2'd2;

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               alive_in;
    } t_item;

    typedef struct packed {
        logic cell_alive;
        logic status;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_PRIME,
        ST_SWEEP
    } t_state;

endpackage

FILE: rtl/life_generation_step.sv
// Read or write of one cell: accepted in IDLE, handled in ACCESS, result strobe
// registered from ACCESS; next word accepted in the cycle the result shows. Advance:
// sweeps the interior rows of the active size (64 by default), one row update per
// cycle through the shared row unit, fed by one memory read port with a registered
// output. Results cannot be stalled. Reset (synchronous): grid dead via per-row
// valid bits, no clearing pass; grid_size back to 64.
module life_generation_step import lgs_pkg::*; #(
    parameter int GRID_SIZE = GRID_MAX
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_item       i_item,
    output logic        o_valid,
    output t_result     o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(GRID_SIZE);
    localparam logic [CFG_W-1:0] SIZE_MAX = CFG_W'(GRID_SIZE);

    // control
    t_state                 r_state, n_state;
    logic                   r_valid;
    t_result                r_res;
    logic [GRID_SIZE-1:0]   r_row_ok;
    logic [CFG_W-1:0]       r_grid_size;

    // datapath
    logic [GRID_SIZE-1:0]   r_mem [GRID_SIZE];
    logic [GRID_SIZE-1:0]   r_mem_q;
    logic                   r_rd_ok;
    logic                   r_rd_live;
    logic [GRID_SIZE-1:0]   r_w0, r_w1, r_raw1;
    logic [AW-1:0]          r_row;
    t_item                  r_item;
    logic                   r_inside, r_wall;

    logic [CFG_W-1:0]       eff_n;
    logic [GRID_SIZE-1:0]   mask;
    logic [GRID_SIZE-1:0]   q_gated, w2, next_row;
    logic                   cfg_wr, cfg_sel;
    logic                   accept;
    logic                   in_inside, in_wall;
    logic                   rd_en;
    logic [CFG_W-1:0]       rd_row;
    logic                   rd_ok, rd_live;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [GRID_SIZE-1:0]   wr_data;
    logic                   win_prime, win_shift;
    logic                   res_en;
    t_result                res_data;
    logic                   last_row;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[2] == REG_GRID_SIZE);
    assign cfg_wr  = psel && penable && pwrite && cfg_sel;
    assign prdata  = cfg_sel ? 32'(r_grid_size) : 32'd0;

    assign eff_n  = (r_grid_size > SIZE_MAX) ? SIZE_MAX : r_grid_size;
    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    always_comb begin
        for (int c = 0; c < GRID_SIZE; c++) begin
            mask[c] = (c != 0) && ((CFG_W'(c) + CFG_W'(1)) < eff_n);
        end
    end

    // incoming coordinate classification
    assign in_inside = ({1'b0, i_item.col} < eff_n) && ({1'b0, i_item.row} < eff_n);
    assign in_wall   = !in_inside || (eff_n < MIN_ACTIVE)
                       || (i_item.col == '0) || (i_item.row == '0)
                       || ({1'b0, i_item.col} == eff_n - CFG_W'(1))
                       || ({1'b0, i_item.row} == eff_n - CFG_W'(1));

    assign q_gated = r_rd_ok ? r_mem_q : '0;
    assign w2      = r_rd_live ? (r_mem_q & mask) : '0;

    // shared row unit: next generation of the row held in r_w1
    always_comb begin
        logic [GRID_SIZE-1:0] up_l, up_r, mid_l, mid_r, dn_l, dn_r;
        logic [3:0]           cnt;
        up_l  = r_w0 << 1;
        up_r  = r_w0 >> 1;
        mid_l = r_w1 << 1;
        mid_r = r_w1 >> 1;
        dn_l  = w2 << 1;
        dn_r  = w2 >> 1;
        for (int c = 0; c < GRID_SIZE; c++) begin
            cnt = 4'(up_l[c]) + 4'(r_w0[c]) + 4'(up_r[c]) + 4'(mid_l[c]) + 4'(mid_r[c])
                + 4'(dn_l[c]) + 4'(w2[c]) + 4'(dn_r[c]);
            next_row[c] = mask[c]
                          && ((cnt == BIRTH_COUNT) || (r_w1[c] && (cnt == SURVIVE_COUNT)));
        end
    end

    assign last_row = (CFG_W'(r_row) == eff_n - CFG_W'(2));

    // sequencer
    always_comb begin
        n_state   = r_state;
        rd_en     = 1'b0;
        rd_row    = '0;
        wr_en     = 1'b0;
        wr_addr   = r_row;
        wr_data   = (r_raw1 & ~mask) | next_row;
        win_prime = 1'b0;
        win_shift = 1'b0;
        res_en    = 1'b0;
        res_data  = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    rd_en = 1'b1;
                    if (i_item.kind == KIND_ADVANCE) begin
                        rd_row  = CFG_W'(1);
                        n_state = (eff_n < MIN_ACTIVE) ? ST_ACCESS : ST_PRIME;
                    end else begin
                        rd_row  = {1'b0, i_item.row};
                        n_state = ST_ACCESS;
                    end
                end
            end
            ST_ACCESS: begin
                res_en  = 1'b1;
                n_state = ST_IDLE;
                wr_addr = r_item.row[AW-1:0];
                wr_data = q_gated;
                wr_data[r_item.col[AW-1:0]] = r_item.alive_in;
                case (r_item.kind)
                    KIND_WRITE: begin
                        res_data.status = r_wall;
                        wr_en           = !r_wall;
                    end
                    KIND_READ: begin
                        res_data.status     = !r_inside;
                        res_data.cell_alive = !r_wall && q_gated[r_item.col[AW-1:0]];
                    end
                    KIND_ADVANCE: begin
                        res_data = '0;
                    end
                    default: begin
                        res_data.status = 1'b1;
                    end
                endcase
            end
            ST_PRIME: begin
                win_prime = 1'b1;
                rd_en     = 1'b1;
                rd_row    = CFG_W'(2);
                n_state   = ST_SWEEP;
            end
            ST_SWEEP: begin
                wr_en     = 1'b1;
                win_shift = 1'b1;
                rd_en     = 1'b1;
                rd_row    = CFG_W'(r_row) + CFG_W'(2);
                if (last_row) begin
                    res_en  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // the wall ring and rows never written read as dead
    assign rd_ok   = (rd_row < SIZE_MAX) && r_row_ok[rd_row[AW-1:0]];
    assign rd_live = rd_ok && (rd_row != '0) && ((rd_row + CFG_W'(1)) < eff_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= 1'b0;
            r_row_ok    <= '0;
            r_grid_size <= GRID_SIZE_RESET;
        end else begin
            r_state <= n_state;
            r_valid <= res_en;
            if (wr_en) begin
                r_row_ok[wr_addr] <= 1'b1;
            end
            if (cfg_wr) begin
                r_grid_size <= pwdata[CFG_W-1:0];
            end
        end
    end

    // cell memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[rd_row[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_ok   <= rd_ok;
            r_rd_live <= rd_live;
        end
        if (accept) begin
            r_item   <= i_item;
            r_inside <= in_inside;
            r_wall   <= in_wall;
        end
        if (win_prime) begin
            r_w0   <= '0;
            r_w1   <= w2;
            r_raw1 <= q_gated;
            r_row  <= AW'(1);
        end
        // advance the three-row window
        if (win_shift) begin
            r_w0   <= r_w1;
            r_w1   <= w2;
            r_raw1 <= q_gated;
            r_row  <= r_row + AW'(1);
        end
        if (res_en) begin
            r_res <= res_data;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

    a_word_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_busy_ends_with_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted word did not start work");

    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> ((CFG_W'(r_row) + CFG_W'(2)) <= eff_n))
        else $error("sweep ran past the last interior row");

endmodule

FILE: tb/life_generation_step_tb.sv
module life_generation_step_tb import lgs_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam logic [2:0] ADDR_GRID_SIZE = {REG_GRID_SIZE, 2'b00};
    localparam int         SWEEP_SLACK  = GRID_MAX + 8;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    t_item       i_item  = '0;
    logic        o_valid;
    t_result     o_result;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    life_generation_step uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor state
    logic [GRID_MAX-1:0] cell_plane [GRID_MAX];
    logic [CFG_W-1:0]    size_reg = GRID_SIZE_RESET;
    t_result             pending_results [$];
    int                  mismatches = 0;
    bit                  start_hi = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("life_generation_step_tb: FAIL");
        $finish;
    end

    function automatic int active_size();
        return (size_reg > GRID_MAX) ? GRID_MAX : int'(size_reg);
    endfunction

    function automatic logic [GRID_MAX-1:0] interior_bits(int n);
        if (n < 3) return '0;
        return ((64'd1 << (n - 1)) - 64'd1) & ~64'd1;
    endfunction

    // Build the next generation from a snapshot of the old one; wall and
    // out-of-range bits count as dead and are left untouched.
    function automatic void advance_generation();
        logic [GRID_MAX-1:0] prev_gen [GRID_MAX];
        logic [GRID_MAX-1:0] mask;
        logic [GRID_MAX-1:0] next_row;
        int n;
        int cnt;
        n = active_size();
        if (n < 3) return;
        mask = interior_bits(n);
        for (int r = 0; r < GRID_MAX; r++)
            prev_gen[r] = (r == 0 || r >= n - 1) ? '0 : (cell_plane[r] & mask);
        for (int r = 1; r < n - 1; r++) begin
            next_row = '0;
            for (int c = 1; c < n - 1; c++) begin
                cnt = 0;
                for (int dr = -1; dr <= 1; dr++)
                    for (int dc = -1; dc <= 1; dc++)
                        if (dr != 0 || dc != 0)
                            cnt += int'(prev_gen[r + dr][c + dc]);
                if (cnt == BIRTH_COUNT || (prev_gen[r][c] && cnt == SURVIVE_COUNT))
                    next_row[c] = 1'b1;
            end
            cell_plane[r] = (cell_plane[r] & ~mask) | next_row;
        end
    endfunction

    function automatic t_result step_cells(t_item w);
        t_result res;
        int n;
        bit in_grid;
        bit wall;
        res = '0;
        n = active_size();
        in_grid = (w.col < n) && (w.row < n);
        wall = !in_grid || n < 3 || w.col == 0 || w.row == 0
               || w.col == n - 1 || w.row == n - 1;
        case (w.kind)
            KIND_WRITE: begin
                if (wall) res.status = 1'b1;
                else cell_plane[w.row][w.col] = w.alive_in;
            end
            KIND_READ: begin
                if (!in_grid) res.status = 1'b1;
                else if (!wall) res.cell_alive = cell_plane[w.row][w.col];
            end
            KIND_ADVANCE: advance_generation();
            default: res.status = 1'b1;
        endcase
        return res;
    endfunction

    function automatic t_item make_word(logic [1:0] kind, int col, int row, int alive);
        t_item w;
        w.kind     = kind;
        w.col      = col[COORD_W-1:0];
        w.row      = row[COORD_W-1:0];
        w.alive_in = alive[0];
        return w;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result word", 32'(o_result), '0);
            end else begin
                want = pending_results.pop_front();
                if (o_result.cell_alive !== want.cell_alive)
                    report_mismatch("cell_alive", 32'(o_result.cell_alive),
                                    32'(want.cell_alive));
                if (o_result.status !== want.status)
                    report_mismatch("status", 32'(o_result.status), 32'(want.status));
            end
        end
    end

    // Hold start high after acceptance; the caller drops it if it idles.
    task automatic send_word(t_item w);
        start    <= 1'b1;
        start_hi  = 1'b1;
        i_item   <= w;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(step_cells(w));
    endtask

    task automatic drop_start();
        if (start_hi) begin
            start   <= 1'b0;
            start_hi = 1'b0;
        end
    endtask

    task automatic sender_gap(int idle_pct);
        if ($urandom_range(99) < idle_pct) begin
            drop_start();
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // Pause until every expected word has come and a sweep could have ended.
    task automatic settle();
        drop_start();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SWEEP_SLACK) @(posedge i_clk);
    endtask

    task automatic write_size(logic [31:0] value);
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_GRID_SIZE;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        size_reg = value[CFG_W-1:0];
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[CFG_W-1:0] !== size_reg)
            report_mismatch("grid_size readback", rd, 32'(size_reg));
        @(posedge i_clk);
    endtask

    task automatic test_cell_access();
        send_word(make_word(KIND_WRITE, 1, 1, 1));
        send_word(make_word(KIND_READ, 1, 1, 0));
        send_word(make_word(KIND_WRITE, 62, 62, 1));
        send_word(make_word(KIND_READ, 62, 62, 0));
        send_word(make_word(KIND_WRITE, 63, 63, 1));
        send_word(make_word(KIND_WRITE, 0, 5, 1));
        send_word(make_word(KIND_READ, 0, 5, 1));
        send_word(make_word(KIND_READ, 63, 63, 0));
        send_word(make_word(KIND_UNUSED, 63, 63, 1));
        send_word(make_word(KIND_WRITE, 1, 1, 0));
        send_word(make_word(KIND_READ, 1, 1, 0));
        settle();
    endtask

    // Vertical blinker in a 5x5 square turns horizontal.
    task automatic test_blinker();
        write_size(32'd5);
        send_word(make_word(KIND_WRITE, 2, 1, 1));
        send_word(make_word(KIND_WRITE, 2, 2, 1));
        send_word(make_word(KIND_WRITE, 2, 3, 1));
        send_word(make_word(KIND_ADVANCE, 0, 0, 0));
        send_word(make_word(KIND_READ, 1, 2, 0));
        send_word(make_word(KIND_READ, 2, 1, 0));
        send_word(make_word(KIND_READ, 10, 2, 0));
        settle();
    endtask

    task automatic test_tiny_sizes();
        write_size(32'd2);
        send_word(make_word(KIND_ADVANCE, 0, 0, 0));
        send_word(make_word(KIND_READ, 1, 1, 0));
        send_word(make_word(KIND_WRITE, 1, 1, 1));
        settle();
        write_size(32'd0);
        send_word(make_word(KIND_READ, 0, 0, 0));
        settle();
        write_size(32'd127);
        send_word(make_word(KIND_READ, 63, 63, 0));
        settle();
        write_size(32'd3);
        send_word(make_word(KIND_ADVANCE, 0, 0, 0));
        settle();
    endtask

    function automatic logic [31:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 55) return $urandom_range(10, 3);
        if (r < 75) return $urandom_range(64, 11);
        if (r < 85) return $urandom_range(2, 0);
        if (r < 92) return $urandom_range(127, 65);
        return 32'd64;
    endfunction

    function automatic int pick_coord(int n);
        if (n == 0 || $urandom_range(99) < 15) return $urandom_range(63);
        return $urandom_range(n - 1);
    endfunction

    function automatic t_item random_word(int n);
        int r;
        logic [1:0] kind;
        r = $urandom_range(99);
        if (r < 45) kind = KIND_READ;
        else if (r < 75) kind = KIND_WRITE;
        else if (r < 92) kind = KIND_ADVANCE;
        else kind = KIND_UNUSED;
        return make_word(kind, pick_coord(n), pick_coord(n), $urandom_range(1));
    endfunction

    // Bursts at one grid size: seed the interior, then mix reads, writes
    // and generations with some noise.
    task automatic test_random(int words, int idle_pct);
        int sent;
        int n;
        int seed_cnt;
        t_item w;
        sent = 0;
        while (sent < words) begin
            settle();
            write_size(pick_size());
            n = active_size();
            seed_cnt = (n >= 3) ? $urandom_range(16, 4) : 0;
            for (int k = 0; k < 50 && sent < words; k++) begin
                if (k < seed_cnt)
                    w = make_word(KIND_WRITE, $urandom_range(n - 2, 1),
                                  $urandom_range(n - 2, 1),
                                  int'($urandom_range(99) < 75));
                else
                    w = random_word(n);
                send_word(w);
                sender_gap(idle_pct);
                sent++;
            end
        end
    endtask

    initial begin
        for (int r = 0; r < GRID_MAX; r++) cell_plane[r] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_cell_access();
        test_blinker();
        test_tiny_sizes();
        test_random(300, 0);
        test_random(250, 85);
        test_random(250, 22);
        settle();

        if (mismatches == 0) begin
            $display("life_generation_step_tb: PASS");
        end else begin
            $display("life_generation_step_tb: FAIL");
        end
        $finish;
    end

endmodule
